[rtl/tilt_feedback_failsafe_monitor_macros.svh]
// ----------------------------------------------------------------------------
// tilt feedback failsafe monitor assertion macros
// shared concurrent check forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef TILT_FEEDBACK_FAILSAFE_MONITOR_MACROS_SVH
`define TILT_FEEDBACK_FAILSAFE_MONITOR_MACROS_SVH

// same-cycle implication
`define TFM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfm check failed: same-cycle implication");

// next-cycle implication
`define TFM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfm check failed: next-cycle implication");

`endif

[rtl/tfm_pkg.sv]
// ----------------------------------------------------------------------------
// tfm_pkg
// types, register indexes and helpers for the tilt feedback failsafe monitor
// ----------------------------------------------------------------------------
package tfm_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CMD_TIMEOUT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARMED_TILT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_IMPROVE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVER_HOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVER_TILT = 3'd5;

    localparam logic [15:0] RST_CMD_TIMEOUT  = 16'd3000;
    localparam logic [15:0] RST_WINDOW       = 16'd1500;
    localparam logic [15:0] RST_ARMED_TILT   = 16'd1280;
    localparam logic [15:0] RST_MIN_IMPROVE  = 16'd154;
    localparam logic [15:0] RST_RECOVER_HOLD = 16'd1200;
    localparam logic [15:0] RST_RECOVER_TILT = 16'd640;

    typedef enum logic
    {
        CHK_FEEDBACK = 1'b0,
        CHK_LINK     = 1'b1
    } check_t;

    typedef struct packed
    {
        logic [15:0] cmd_timeout_ms;
        logic [15:0] window_ms;
        logic [15:0] armed_tilt;
        logic [15:0] min_improvement;
        logic [15:0] recover_hold_ms;
        logic [15:0] recover_tilt;
    } cfg_t;

    typedef struct packed
    {
        check_t             cmd;
        logic [31:0]        now_ms;
        logic signed [16:0] pitch;
        logic signed [16:0] roll;
        logic               actuator_active;
        logic               stop_commanded;
        logic [31:0]        last_cmd_time;
    } item_t;

    typedef struct packed
    {
        logic failsafe_active;
        logic feedback_fault;
        logic timeout_fault;
        logic stop_motors;
    } res_t;

    typedef struct packed
    {
        logic timeout_flag;
        logic feedback_flag;
        logic monitor_armed;
        logic recover_valid;
    } status_t;

    // magnitude of a 17-bit two's complement angle, clipped to 16 bits
    function automatic logic [15:0] mag_sat(input logic signed [16:0] v);
        logic [16:0] m;
        begin
            m = v[16] ? 17'(-v) : 17'(v);
            mag_sat = m[16] ? 16'hFFFF : m[15:0];
        end
    endfunction

    function automatic logic [15:0] tilt_of(input logic signed [16:0] p,
                                            input logic signed [16:0] r);
        logic [15:0] a;
        logic [15:0] b;
        begin
            a = mag_sat(p);
            b = mag_sat(r);
            tilt_of = (a > b) ? a : b;
        end
    endfunction

endpackage

[rtl/tfm_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tfm_cfg_regs
// configuration register file, write only, indexed writes
// ----------------------------------------------------------------------------
module tfm_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tfm_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [tfm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output tfm_pkg::cfg_t                 cfg
);
    import tfm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_CMD_TIMEOUT:  cfg_next.cmd_timeout_ms  = cfg_wdata;
                REG_WINDOW:       cfg_next.window_ms       = cfg_wdata;
                REG_ARMED_TILT:   cfg_next.armed_tilt      = cfg_wdata;
                REG_MIN_IMPROVE:  cfg_next.min_improvement = cfg_wdata;
                REG_RECOVER_HOLD: cfg_next.recover_hold_ms = cfg_wdata;
                REG_RECOVER_TILT: cfg_next.recover_tilt    = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cmd_timeout_ms  <= RST_CMD_TIMEOUT;
            cfg_reg.window_ms       <= RST_WINDOW;
            cfg_reg.armed_tilt      <= RST_ARMED_TILT;
            cfg_reg.min_improvement <= RST_MIN_IMPROVE;
            cfg_reg.recover_hold_ms <= RST_RECOVER_HOLD;
            cfg_reg.recover_tilt    <= RST_RECOVER_TILT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/tfm_core.sv]
// ----------------------------------------------------------------------------
// tfm_core
// fault state and the state update for one feedback or link check
// ----------------------------------------------------------------------------
module tfm_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  tfm_pkg::cfg_t    cfg,
    input  logic             step_en,
    input  tfm_pkg::item_t   item,
    output tfm_pkg::res_t    res,
    output tfm_pkg::status_t status
);
    import tfm_pkg::*;

    logic        timeout_flag_reg,  timeout_flag_next;
    logic        feedback_flag_reg, feedback_flag_next;
    logic        armed_reg,         armed_next;
    logic [31:0] window_start_reg,  window_start_next;
    logic [15:0] initial_tilt_reg,  initial_tilt_next;
    logic [15:0] best_tilt_reg,     best_tilt_next;
    logic [31:0] recover_start_reg, recover_start_next;
    logic        recover_valid_reg, recover_valid_next;
    logic        raised;

    logic [15:0]        tilt;
    logic [15:0]        best_upd;
    logic [31:0]        win_elapsed;
    logic [31:0]        link_elapsed;
    logic [31:0]        hold_elapsed;
    logic signed [16:0] gain;

    assign tilt         = tilt_of(item.pitch, item.roll);
    assign best_upd     = (tilt < best_tilt_reg) ? tilt : best_tilt_reg;
    assign win_elapsed  = item.now_ms - window_start_reg;
    assign link_elapsed = item.now_ms - item.last_cmd_time;
    assign hold_elapsed = item.now_ms - recover_start_reg;
    assign gain         = $signed({1'b0, initial_tilt_reg}) - $signed({1'b0, best_upd});

    always_comb
    begin
        timeout_flag_next  = timeout_flag_reg;
        feedback_flag_next = feedback_flag_reg;
        armed_next         = armed_reg;
        window_start_next  = window_start_reg;
        initial_tilt_next  = initial_tilt_reg;
        best_tilt_next     = best_tilt_reg;
        recover_start_next = recover_start_reg;
        recover_valid_next = recover_valid_reg;
        raised             = 1'b0;

        case (item.cmd)
            CHK_FEEDBACK:
            begin
                if (feedback_flag_reg || timeout_flag_reg || (tilt < cfg.armed_tilt)
                    || !item.actuator_active)
                begin
                    armed_next        = 1'b0;
                    window_start_next = '0;
                    initial_tilt_next = '0;
                    best_tilt_next    = '0;
                end
                else if (!armed_reg)
                begin
                    armed_next        = 1'b1;
                    window_start_next = item.now_ms;
                    initial_tilt_next = tilt;
                    best_tilt_next    = tilt;
                end
                else
                begin
                    best_tilt_next = best_upd;
                    if (win_elapsed >= {16'd0, cfg.window_ms})
                    begin
                        // window over: either not enough progress or start a new one
                        if (gain < $signed({1'b0, cfg.min_improvement}))
                        begin
                            feedback_flag_next = 1'b1;
                            raised             = 1'b1;
                            armed_next         = 1'b0;
                            window_start_next  = '0;
                            initial_tilt_next  = '0;
                            best_tilt_next     = '0;
                        end
                        else
                        begin
                            initial_tilt_next = best_upd;
                            window_start_next = item.now_ms;
                        end
                    end
                end
            end
            CHK_LINK:
            begin
                // no command received yet leaves everything alone
                if (item.last_cmd_time != '0)
                begin
                    if (link_elapsed > {16'd0, cfg.cmd_timeout_ms})
                    begin
                        raised             = !timeout_flag_reg;
                        timeout_flag_next  = 1'b1;
                        recover_valid_next = 1'b0;
                        recover_start_next = '0;
                    end
                    else
                    begin
                        timeout_flag_next = 1'b0;
                        if (!feedback_flag_reg || !item.stop_commanded
                            || (tilt > cfg.recover_tilt) || item.actuator_active)
                        begin
                            recover_valid_next = 1'b0;
                            recover_start_next = '0;
                        end
                        else if (!recover_valid_reg)
                        begin
                            recover_valid_next = 1'b1;
                            recover_start_next = item.now_ms;
                        end
                        else if (hold_elapsed >= {16'd0, cfg.recover_hold_ms})
                        begin
                            feedback_flag_next = 1'b0;
                            armed_next         = 1'b0;
                            window_start_next  = '0;
                            initial_tilt_next  = '0;
                            best_tilt_next     = '0;
                            recover_valid_next = 1'b0;
                            recover_start_next = '0;
                        end
                    end
                end
            end
            default:
            begin
                raised = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_flag_reg  <= 1'b0;
            feedback_flag_reg <= 1'b0;
            armed_reg         <= 1'b0;
            window_start_reg  <= '0;
            initial_tilt_reg  <= '0;
            best_tilt_reg     <= '0;
            recover_start_reg <= '0;
            recover_valid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            timeout_flag_reg  <= timeout_flag_next;
            feedback_flag_reg <= feedback_flag_next;
            armed_reg         <= armed_next;
            window_start_reg  <= window_start_next;
            initial_tilt_reg  <= initial_tilt_next;
            best_tilt_reg     <= best_tilt_next;
            recover_start_reg <= recover_start_next;
            recover_valid_reg <= recover_valid_next;
        end
    end

    assign res.failsafe_active = timeout_flag_next | feedback_flag_next;
    assign res.feedback_fault  = feedback_flag_next;
    assign res.timeout_fault   = timeout_flag_next;
    assign res.stop_motors     = raised;

    assign status.timeout_flag  = timeout_flag_reg;
    assign status.feedback_flag = feedback_flag_reg;
    assign status.monitor_armed = armed_reg;
    assign status.recover_valid = recover_valid_reg;

endmodule

[rtl/tilt_feedback_failsafe_monitor.sv]
// ----------------------------------------------------------------------------
// tilt_feedback_failsafe_monitor
// stream wrapper: input register, check core, result register
// ----------------------------------------------------------------------------
// Takes one sample word per clock while s_tready is high and returns one
// result word per sample, in order. A word waits in the input register while
// tfm_core checks it and moves to the result register when the result slot is
// free. Sustained throughput is one word per cycle, set by the fault state
// update in tfm_core, which writes back its state before the next check, so
// each check sees the state left by the previous one. s_tready drops only
// while the result register is full and not being taken. Configuration
// writes take effect at the next edge and are meant to be done while idle.
module tilt_feedback_failsafe_monitor
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_we,
    input  logic [tfm_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [tfm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // sample stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // now_ms[31:0], pitch[48:32], roll[65:49], actuator_active[66],
    // stop_commanded[67], last_cmd_time[99:68], zero fill[103:100]
    input  logic [tfm_pkg::IN_TDATA_W-1:0]  s_tdata,
    // cmd[0]
    input  logic                            s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // failsafe_active[0], feedback_fault[1], timeout_fault[2], stop_motors[3],
    // zero fill[7:4]
    output logic [tfm_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import tfm_pkg::*;

    `include "tilt_feedback_failsafe_monitor_macros.svh"

    cfg_t    cfg;
    item_t   in_item;
    item_t   item_reg;
    logic    in_valid_reg;
    res_t    core_res;
    res_t    res_reg;
    logic    out_valid_reg;
    status_t status;
    logic    advance;

    assign in_item.cmd             = check_t'(s_tuser);
    assign in_item.now_ms          = s_tdata[31:0];
    assign in_item.pitch           = s_tdata[48:32];
    assign in_item.roll            = s_tdata[65:49];
    assign in_item.actuator_active = s_tdata[66];
    assign in_item.stop_commanded  = s_tdata[67];
    assign in_item.last_cmd_time   = s_tdata[99:68];

    // word in the input register moves on when the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= in_item;
        end
    end

    tfm_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tfm_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step_en (advance),
        .item    (item_reg),
        .res     (core_res),
        .status  (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, res_reg.stop_motors, res_reg.timeout_fault,
                       res_reg.feedback_fault, res_reg.failsafe_active};

    // a latched feedback fault always leaves the tilt monitor disarmed
    `TFM_ASSERT_IMPL(a_fault_disarms, status.feedback_flag, !status.monitor_armed)
    // a recovery window only runs while the feedback fault is held
    `TFM_ASSERT_IMPL(a_recover_needs_fault, status.recover_valid, status.feedback_flag)
    // a raised fault shows up in the next result word together with failsafe_active
    `TFM_ASSERT_NEXT(a_raise_reported, advance && core_res.stop_motors,
                     m_tvalid && m_tdata[3] && m_tdata[0])

endmodule
